/* src/stepper_command_frame_encoder_assert.svh */
// Assertion macros for the stepper command frame encoder.
// Used by the port checker; needs nothing else.
`ifndef STEPPER_COMMAND_FRAME_ENCODER_ASSERT_SVH
`define STEPPER_COMMAND_FRAME_ENCODER_ASSERT_SVH

// clocked assertion, disabled while reset is high
`define SCFE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SCFE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/scfe_pkg.sv */
// Shared types and constants of the stepper command frame encoder.
// No dependencies; imported by every RTL module.
package scfe_pkg;

  typedef logic [7:0] byte_t;

  localparam int FRAME_BYTES = 9;
  localparam int LEN_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int MSTEP_W     = 9;
  localparam int RATIO_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MICROSTEPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO = 2'd1;

  localparam logic [MSTEP_W-1:0] MSTEP_RESET = 9'd16;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd256;

  typedef enum logic [2:0] {
    ACT_ENABLE    = 3'd0,
    ACT_DISABLE   = 3'd1,
    ACT_MICROSTEP = 3'd2,
    ACT_ZERO      = 3'd3,
    ACT_SPEED     = 3'd4,
    ACT_POSITION  = 3'd5,
    ACT_STOP      = 3'd6
  } action_t;

  localparam byte_t CMD_ENABLE    = 8'hF3;
  localparam byte_t CMD_MICROSTEP = 8'h84;
  localparam byte_t CMD_ZERO      = 8'h0A;
  localparam byte_t CMD_SPEED     = 8'hF6;
  localparam byte_t CMD_POSITION  = 8'hFD;
  localparam byte_t ARG_ON        = 8'h01;
  localparam byte_t ARG_OFF       = 8'h00;
  localparam byte_t ARG_ZERO      = 8'h6D;
  localparam byte_t ARG_STOP      = 8'h12;
  localparam byte_t STOP_FILL     = 8'hFF;
  localparam byte_t DIR_FLAG      = 8'h10;
  localparam byte_t REPLY_XOR     = 8'h02;

  localparam logic [11:0] SPEED_MAX = 12'hFFF;
  localparam logic [23:0] PULSE_MAX = 24'hFFFFFF;
  // scaled count at or above this gives a quotient beyond 24 bits
  localparam logic [35:0] SAT_LIMIT = 36'd150994944;
  localparam logic [28:0] RECIP9    = 29'h1C71C71C;
  localparam int          DIV9      = 9;

  typedef struct packed {
    logic [2:0]         action;
    byte_t              addr;
    logic signed [12:0] speed;
    byte_t              arg;
    logic signed [7:0]  dir;
    logic signed [23:0] angle;
  } cmd_in_t;

  typedef struct packed {
    logic [2:0]  action;
    byte_t       addr;
    logic [11:0] mag;
    logic        fwd;
    byte_t       arg;
  } cmd_t;

  typedef struct packed {
    byte_t [FRAME_BYTES-1:0] bytes;
    logic [LEN_W-1:0]        len;
    byte_t                   addr;
  } frame_t;

endpackage

/* src/scfe_pulse_pipe.sv */
// Six-stage request pipeline: decode, pulse-count multiplies, divide by nine,
// frame assembly with check byte. Depends on scfe_pkg.
module scfe_pulse_pipe (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  scfe_pkg::cmd_in_t             in_cmd,
  input  logic [scfe_pkg::MSTEP_W-1:0]  microsteps,
  input  logic [scfe_pkg::RATIO_W-1:0]  gear_ratio_q8,
  output logic                          out_valid,
  input  logic                          out_ready,
  output scfe_pkg::frame_t              out_frame
);
  import scfe_pkg::*;

  logic [6:1] stage_valid;
  logic [6:1] stage_ready;

  cmd_t        c1, c2, c3, c4, c5;
  logic [23:0] amag1;
  logic [32:0] prod2;
  logic [48:0] prod3;
  logic [27:0] y4, y5;
  logic        sat4, sat5;
  logic [56:0] prod5;
  frame_t      frame6;

  logic              neg;
  logic [12:0]       mag13;
  logic              spd_fwd;
  logic              pos_fwd;
  logic              in_ok;
  cmd_t              c1_next;
  logic [23:0]       amag_next;
  logic [51:0]       x5;
  logic [35:0]       y_full;
  logic [23:0]       q0;
  logic [27:0]       rem;
  logic [23:0]       pulse;
  byte_t [FRAME_BYTES-1:0] fb;
  logic [LEN_W-1:0]  n;
  byte_t             chk;

  always_comb begin
    stage_ready[6] = !stage_valid[6] || out_ready;
    for (int k = 1; k < 6; k++) begin
      stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end
  end

  assign in_ready  = stage_ready[1];
  assign out_valid = stage_valid[6];
  assign out_frame = frame6;
  assign in_ok     = in_valid && (in_cmd.action <= 3'(ACT_STOP));

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_ready[1]) stage_valid[1] <= in_ok;
      for (int k = 2; k <= 6; k++) begin
        if (stage_ready[k]) stage_valid[k] <= stage_valid[k-1];
      end
    end
  end

  // decode
  always_comb begin
    neg       = in_cmd.speed[12];
    mag13     = neg ? (~in_cmd.speed + 13'd1) : in_cmd.speed;
    spd_fwd   = in_cmd.addr[0] ? (!neg && (in_cmd.speed != 13'sd0)) : neg;
    pos_fwd   = (in_cmd.dir != 8'sd0) && (in_cmd.angle != 24'sd0) &&
                (in_cmd.dir[7] == in_cmd.angle[23]);
    amag_next = in_cmd.angle[23] ? (~in_cmd.angle + 24'd1) : in_cmd.angle;
    c1_next.action = in_cmd.action;
    c1_next.addr   = in_cmd.addr;
    c1_next.mag    = mag13[12] ? SPEED_MAX : mag13[11:0];
    c1_next.fwd    = (in_cmd.action == 3'(ACT_SPEED)) ? spd_fwd : pos_fwd;
    c1_next.arg    = in_cmd.arg;
  end

  always_ff @(posedge clk) begin
    if (stage_ready[1]) begin
      c1    <= c1_next;
      amag1 <= amag_next;
    end
    if (stage_ready[2]) begin
      c2    <= c1;
      prod2 <= {9'd0, amag1} * {24'd0, microsteps};
    end
    if (stage_ready[3]) begin
      c3    <= c2;
      prod3 <= 49'(prod2) * 49'(gear_ratio_q8);
    end
    if (stage_ready[4]) begin
      c4   <= c3;
      sat4 <= y_full >= SAT_LIMIT;
      y4   <= y_full[27:0];
    end
    if (stage_ready[5]) begin
      c5    <= c4;
      prod5 <= 57'(y4) * 57'(RECIP9);
      y5    <= y4;
      sat5  <= sat4;
    end
    if (stage_ready[6]) begin
      frame6.bytes <= fb;
      frame6.len   <= n + LEN_W'(1);
      frame6.addr  <= c5.addr;
    end
  end

  // times five, drop the 2^16 part of the divisor
  always_comb begin
    x5     = {3'd0, prod3} + {1'b0, prod3, 2'b00};
    y_full = x5[51:16];
  end

  // quotient by nine: reciprocal estimate, one correction
  always_comb begin
    q0    = prod5[55:32];
    rem   = y5 - ({4'd0, q0} * 28'(DIV9));
    pulse = sat5 ? PULSE_MAX : ((rem >= 28'(DIV9)) ? (q0 + 24'd1) : q0);
  end

  always_comb begin
    fb    = '0;
    fb[0] = c5.addr;
    n     = LEN_W'(3);
    case (c5.action)
      ACT_ENABLE: begin
        fb[1] = CMD_ENABLE;
        fb[2] = ARG_ON;
      end
      ACT_DISABLE: begin
        fb[1] = CMD_ENABLE;
        fb[2] = ARG_OFF;
      end
      ACT_MICROSTEP: begin
        fb[1] = CMD_MICROSTEP;
        fb[2] = c5.arg;
      end
      ACT_ZERO: begin
        fb[1] = CMD_ZERO;
        fb[2] = ARG_ZERO;
      end
      ACT_SPEED: begin
        fb[1] = CMD_SPEED;
        fb[2] = (c5.fwd ? DIR_FLAG : 8'h00) | {4'd0, c5.mag[11:8]};
        fb[3] = c5.mag[7:0];
        fb[4] = c5.arg;
        n     = LEN_W'(5);
      end
      ACT_POSITION: begin
        fb[1] = CMD_POSITION;
        fb[2] = (c5.fwd ? DIR_FLAG : 8'h00) | {4'd0, c5.mag[11:8]};
        fb[3] = c5.mag[7:0];
        fb[4] = c5.arg;
        fb[5] = pulse[23:16];
        fb[6] = pulse[15:8];
        fb[7] = pulse[7:0];
        n     = LEN_W'(8);
      end
      ACT_STOP: begin
        fb[1] = CMD_POSITION;
        fb[2] = ARG_STOP;
        fb[3] = STOP_FILL;
        fb[4] = STOP_FILL;
        n     = LEN_W'(8);
      end
      default: begin
        n = LEN_W'(3);
      end
    endcase
    chk = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      chk = chk ^ fb[i];
    end
    fb[n] = chk;
  end

endmodule

/* src/scfe_serializer.sv */
// Frame buffer and byte serializer with registered byte output.
// Depends on scfe_pkg.
module scfe_serializer #(
  parameter int MAX_FRAME_BYTES = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             frame_valid,
  output logic             frame_ready,
  input  scfe_pkg::frame_t frame,
  output logic             byte_valid,
  input  logic             byte_stall,
  output logic [7:0]       frame_byte,
  output logic             last_byte,
  output logic [7:0]       reply_address,
  output logic [7:0]       reply_check
);
  import scfe_pkg::*;

  localparam int IDX_W = $clog2(MAX_FRAME_BYTES);
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  byte_t            frame_buf [MAX_FRAME_BYTES];
  logic [CNT_W-1:0] len;
  logic [IDX_W-1:0] idx;
  logic             busy;
  byte_t            raddr;
  byte_t            rchk;

  logic out_load;
  logic emit;
  logic last;
  logic take;

  assign out_load    = !byte_valid || !byte_stall;
  assign emit        = busy && out_load;
  assign last        = CNT_W'(idx) == (len - CNT_W'(1));
  assign frame_ready = !busy || (emit && last);
  assign take        = frame_valid && frame_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      byte_valid <= 1'b0;
      idx        <= '0;
    end else begin
      if (take) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (emit) begin
        if (last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
      if (emit) begin
        byte_valid <= 1'b1;
      end else if (out_load) begin
        byte_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        frame_buf[i] <= frame.bytes[i];
      end
      len   <= CNT_W'(frame.len);
      raddr <= (frame.addr == 8'd0) ? 8'd1 : frame.addr;
      rchk  <= ((frame.addr == 8'd0) ? 8'd1 : frame.addr) ^ REPLY_XOR;
    end
    if (emit) begin
      frame_byte    <= frame_buf[idx];
      last_byte     <= last;
      reply_address <= raddr;
      reply_check   <= rchk;
    end
  end

endmodule

/* src/stepper_command_frame_encoder.sv */
// Stepper command frame encoder: the first byte of a frame leaves after the request
// is taken, through the six pipeline stages, frame buffer and output register.
// One byte per cycle while byte_stall is low, set by the single-byte output of the
// serializer; a frame has 4, 6 or 9 bytes, and the next is taken as its last is sent.
// Synchronous reset clears all valid bits, microsteps to 16, gear ratio to 256.
module stepper_command_frame_encoder #(
  parameter int MAX_FRAME_BYTES = 9
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  logic [2:0]                       action,
  input  logic [7:0]                       motor_address,
  input  logic signed [12:0]               speed_value,
  input  logic [7:0]                       arg_byte,
  input  logic signed [7:0]                direction,
  input  logic signed [23:0]               angle_q8,
  output logic                             byte_valid,
  input  logic                             byte_stall,
  output logic [7:0]                       frame_byte,
  output logic                             last_byte,
  output logic [7:0]                       reply_address,
  output logic [7:0]                       reply_check,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scfe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import scfe_pkg::*;

  logic [MSTEP_W-1:0] microsteps;
  logic [RATIO_W-1:0] gear_ratio_q8;
  cmd_in_t            cmd;
  logic               pipe_ready;
  logic               frame_valid;
  logic               frame_ready;
  frame_t             frame;

  assign cfg_ready = 1'b1;
  assign cmd_stall = !pipe_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      microsteps    <= MSTEP_RESET;
      gear_ratio_q8 <= RATIO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MICROSTEPS: microsteps    <= cfg_data[MSTEP_W-1:0];
        CFG_GEAR_RATIO: gear_ratio_q8 <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd.action = action;
    cmd.addr   = motor_address;
    cmd.speed  = speed_value;
    cmd.arg    = arg_byte;
    cmd.dir    = direction;
    cmd.angle  = angle_q8;
  end

  scfe_pulse_pipe u_pipe (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (cmd_valid),
    .in_ready      (pipe_ready),
    .in_cmd        (cmd),
    .microsteps    (microsteps),
    .gear_ratio_q8 (gear_ratio_q8),
    .out_valid     (frame_valid),
    .out_ready     (frame_ready),
    .out_frame     (frame)
  );

  scfe_serializer #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_ser (
    .clk           (clk),
    .rst           (rst),
    .frame_valid   (frame_valid),
    .frame_ready   (frame_ready),
    .frame         (frame),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .frame_byte    (frame_byte),
    .last_byte     (last_byte),
    .reply_address (reply_address),
    .reply_check   (reply_check)
  );

endmodule

/* src/scfe_checker.sv */
// Port-level checker for the stepper command frame encoder and its bind.
// Depends on stepper_command_frame_encoder_assert.svh.
`include "stepper_command_frame_encoder_assert.svh"

module scfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       byte_valid,
  input logic       byte_stall,
  input logic [7:0] frame_byte,
  input logic       last_byte,
  input logic [7:0] reply_address,
  input logic [7:0] reply_check
);

  `SCFE_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !byte_valid, "byte valid after reset")
  `SCFE_ASSERT(a_hold, clk, rst, byte_valid && byte_stall |=> byte_valid && $stable(frame_byte) && $stable(last_byte), "stalled byte changed")
  `SCFE_ASSERT(a_reply, clk, rst, byte_valid |-> (reply_check == (reply_address ^ 8'h02)) && (reply_address != 8'd0), "bad reply fields")
  `SCFE_ASSERT(a_burst, clk, rst, byte_valid && !byte_stall && !last_byte |=> byte_valid && $stable(reply_address), "frame broken up")

endmodule

bind stepper_command_frame_encoder scfe_checker u_scfe_checker (.*);

/* bench/tb_stepper_command_frame_encoder.sv */
// Testbench for the stepper command frame encoder: drives commands and register writes,
// predicts every frame byte with its reply fields and checks the bytes in order.
// Depends on scfe_pkg and the stepper_command_frame_encoder top level.
module tb_stepper_command_frame_encoder;
  import scfe_pkg::*;

  localparam logic [2:0]           ACT_UNUSED  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 5000;

  typedef struct {
    byte_t data;
    logic  last;
    byte_t raddr;
    byte_t rchk;
  } frame_byte_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  logic [2:0] action = '0;
  logic [7:0] motor_address = '0;
  logic signed [12:0] speed_value = '0;
  logic [7:0] arg_byte = '0;
  logic signed [7:0] direction = '0;
  logic signed [23:0] angle_q8 = '0;
  logic byte_valid;
  logic byte_stall = 1'b0;
  logic [7:0] frame_byte;
  logic last_byte;
  logic [7:0] reply_address;
  logic [7:0] reply_check;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [MSTEP_W-1:0] model_msteps = MSTEP_RESET;
  logic [RATIO_W-1:0] model_ratio = RATIO_RESET;
  frame_byte_rec_t pending_bytes[$];
  frame_byte_rec_t want;
  int mismatch_count = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;

  stepper_command_frame_encoder u_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .action(action), .motor_address(motor_address), .speed_value(speed_value),
    .arg_byte(arg_byte), .direction(direction), .angle_q8(angle_q8),
    .byte_valid(byte_valid), .byte_stall(byte_stall),
    .frame_byte(frame_byte), .last_byte(last_byte),
    .reply_address(reply_address), .reply_check(reply_check),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int pick_wait();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic void encode_frame(input logic [2:0] act, input byte_t addr,
      input logic signed [12:0] spd, input byte_t arg, input logic signed [7:0] dir,
      input logic signed [23:0] ang);
    byte_t fb [0:8];
    int n;
    int k;
    logic [12:0] mag13;
    logic [11:0] mag;
    logic fwd;
    logic [23:0] amag;
    logic [63:0] pulses;
    byte_t chk;
    byte_t raddr;
    frame_byte_rec_t rec;
    mag13 = spd[12] ? 13'(-spd) : 13'(spd);
    mag = (mag13 > 13'd4095) ? SPEED_MAX : mag13[11:0];
    fb[0] = addr;
    n = 0;
    case (act)
      ACT_ENABLE: begin
        fb[1] = CMD_ENABLE; fb[2] = ARG_ON; n = 3;
      end
      ACT_DISABLE: begin
        fb[1] = CMD_ENABLE; fb[2] = ARG_OFF; n = 3;
      end
      ACT_MICROSTEP: begin
        fb[1] = CMD_MICROSTEP; fb[2] = arg; n = 3;
      end
      ACT_ZERO: begin
        fb[1] = CMD_ZERO; fb[2] = ARG_ZERO; n = 3;
      end
      ACT_SPEED: begin
        fwd = addr[0] ? (!spd[12] && spd != 0) : spd[12];
        fb[1] = CMD_SPEED;
        fb[2] = (fwd ? DIR_FLAG : 8'h00) | {4'h0, mag[11:8]};
        fb[3] = mag[7:0];
        fb[4] = arg;
        n = 5;
      end
      ACT_POSITION: begin
        fwd = (dir != 0) && (ang != 0) && (dir[7] == ang[23]);
        amag = ang[23] ? 24'(-ang) : 24'(ang);
        pulses = 64'(amag) * 64'(model_msteps) * 64'(model_ratio) * 64'd5 / 64'd589824;
        if (pulses > 64'(PULSE_MAX)) pulses = 64'(PULSE_MAX);
        fb[1] = CMD_POSITION;
        fb[2] = (fwd ? DIR_FLAG : 8'h00) | {4'h0, mag[11:8]};
        fb[3] = mag[7:0];
        fb[4] = arg;
        fb[5] = pulses[23:16];
        fb[6] = pulses[15:8];
        fb[7] = pulses[7:0];
        n = 8;
      end
      ACT_STOP: begin
        fb[1] = CMD_POSITION; fb[2] = ARG_STOP;
        fb[3] = STOP_FILL; fb[4] = STOP_FILL;
        fb[5] = 8'h00; fb[6] = 8'h00; fb[7] = 8'h00;
        n = 8;
      end
      default: n = 0;
    endcase
    if (n == 0) return;
    chk = fb[0];
    for (k = 1; k < n; k++) chk ^= fb[k];
    fb[n] = chk;
    raddr = (addr == 8'h00) ? 8'h01 : addr;
    for (k = 0; k <= n; k++) begin
      rec.data = fb[k];
      rec.last = (k == n);
      rec.raddr = raddr;
      rec.rchk = raddr ^ REPLY_XOR;
      pending_bytes.push_back(rec);
    end
  endfunction

  task automatic send_cmd(input logic [2:0] act, input byte_t addr,
      input logic signed [12:0] spd, input byte_t arg, input logic signed [7:0] dir,
      input logic signed [23:0] ang);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    action <= act;
    motor_address <= addr;
    speed_value <= spd;
    arg_byte <= arg;
    direction <= dir;
    angle_q8 <= ang;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    encode_frame(act, addr, spd, arg, dir, ang);
  endtask

  task automatic wait_frames_out();
    cmd_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_frames_out();
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_MICROSTEPS) model_msteps = data[MSTEP_W-1:0];
    else if (idx == CFG_GEAR_RATIO) model_ratio = data;
  endtask

  task automatic send_random_cmd(output bit counted);
    logic [31:0] r;
    logic [2:0] act;
    byte_t addr;
    logic [12:0] spd;
    logic [7:0] dir;
    logic [23:0] ang;
    logic [23:0] small_ang;
    r = $urandom;
    act = (r[3:0] == 4'd0) ? ACT_UNUSED : 3'($urandom_range(0, 6));
    addr = (r[6:4] == 3'd0) ? 8'h00 : 8'($urandom);
    dir = (r[9:7] == 3'd0) ? 8'h00 : 8'($urandom);
    case (r[11:10])
      2'd0: begin
        case (r[13:12])
          2'd0: spd = 13'h1000;
          2'd1: spd = 13'h0FFF;
          2'd2: spd = 13'h1001;
          default: spd = 13'h0000;
        endcase
      end
      default: spd = 13'($urandom);
    endcase
    small_ang = 24'($urandom_range(0, 4095));
    case (r[15:14])
      2'd0: ang = 24'($urandom);
      2'd1: begin
        case (r[17:16])
          2'd0: ang = 24'h800000;
          2'd1: ang = 24'h7FFFFF;
          2'd2: ang = 24'h000000;
          default: ang = 24'h000001;
        endcase
      end
      default: ang = r[18] ? -small_ang : small_ang;
    endcase
    send_cmd(act, addr, spd, 8'($urandom), dir, ang);
    counted = (act != ACT_UNUSED);
  endtask

  task automatic test_directed_frames();
    send_cmd(ACT_ENABLE, 8'h00, 13'sd0, 8'h00, 8'sd0, 24'sd0);
    send_cmd(ACT_DISABLE, 8'hFF, 13'sd0, 8'hFF, 8'sd0, 24'sd0);
    send_cmd(ACT_MICROSTEP, 8'h01, 13'sd0, 8'h00, 8'sd0, 24'sd0);
    send_cmd(ACT_MICROSTEP, 8'h02, 13'sd0, 8'hFF, 8'sd0, 24'sd0);
    send_cmd(ACT_ZERO, 8'h01, 13'sd0, 8'h00, 8'sd0, 24'sd0);
    send_cmd(ACT_SPEED, 8'h02, 13'sd4095, 8'hFF, 8'sd0, 24'sd0);
    send_cmd(ACT_SPEED, 8'h03, -13'sd4095, 8'h00, 8'sd0, 24'sd0);
    send_cmd(ACT_SPEED, 8'h04, 13'sh1000, 8'h55, 8'sd0, 24'sd0);
    send_cmd(ACT_SPEED, 8'h05, 13'sd0, 8'hAA, 8'sd0, 24'sd0);
    send_cmd(ACT_POSITION, 8'h07, 13'sd4095, 8'hFF, 8'sd127, 24'sh7FFFFF);
    send_cmd(ACT_POSITION, 8'h08, 13'sh1000, 8'h01, -8'sd128, 24'sh800000);
    send_cmd(ACT_POSITION, 8'h09, -13'sd1, 8'h10, 8'sd0, 24'sd2560);
    send_cmd(ACT_POSITION, 8'h0A, 13'sd100, 8'h20, 8'sd1, 24'sd0);
    send_cmd(ACT_POSITION, 8'h0B, 13'sd100, 8'h20, -8'sd1, 24'sd4096);
    send_cmd(ACT_UNUSED, 8'h0C, 13'sd1, 8'h01, 8'sd1, 24'sd1);
    send_cmd(ACT_STOP, 8'hFF, -13'sd4095, 8'hFF, -8'sd1, -24'sd1);
    wait_frames_out();
  endtask

  task automatic test_config_extremes();
    write_cfg(CFG_MICROSTEPS, 16'hFFFF);
    write_cfg(CFG_GEAR_RATIO, 16'hFFFF);
    send_cmd(ACT_POSITION, 8'h11, 13'sd4095, 8'h00, 8'sd5, 24'sh7FFFFF);
    send_cmd(ACT_POSITION, 8'h12, 13'sd1, 8'h00, 8'sd5, 24'sd1);
    write_cfg(CFG_MICROSTEPS, 16'd0);
    send_cmd(ACT_POSITION, 8'h13, 13'sd7, 8'h03, 8'sd5, 24'sh7FFFFF);
    write_cfg(CFG_MICROSTEPS, 16'd256);
    write_cfg(CFG_GEAR_RATIO, 16'd0);
    send_cmd(ACT_POSITION, 8'h14, 13'sd7, 8'h03, -8'sd5, -24'sd9999);
    write_cfg(CFG_MICROSTEPS, 16'd1);
    write_cfg(CFG_GEAR_RATIO, 16'd1);
    send_cmd(ACT_POSITION, 8'h15, 13'sd7, 8'h03, -8'sd5, 24'sh800000);
    write_cfg(CFG_SPARE_A, 16'hFFFF);
    write_cfg(CFG_SPARE_B, 16'h0000);
    send_cmd(ACT_POSITION, 8'h16, 13'sd7, 8'h03, 8'sd5, 24'sh7FFFFF);
    wait_frames_out();
  endtask

  task automatic run_random_phase(input logic [CFG_DATA_W-1:0] msteps,
      input logic [CFG_DATA_W-1:0] ratio, input int count);
    int done;
    bit counted;
    write_cfg(CFG_MICROSTEPS, msteps);
    write_cfg(CFG_GEAR_RATIO, ratio);
    if ($urandom_range(0, 1) == 1)
      write_cfg(2'($urandom_range(2, 3)), 16'($urandom));
    done = 0;
    while (done < count) begin
      send_random_cmd(counted);
      if (counted) done++;
    end
    wait_frames_out();
  endtask

  task automatic test_random_traffic();
    run_random_phase(16'd16, 16'd256, 30);
    run_random_phase(16'd256, 16'd65535, 30);
    no_idle = 1'b1;
    run_random_phase(16'd1, 16'd1, 30);
    no_idle = 1'b0;
    run_random_phase(16'($urandom), 16'($urandom), 25);
    run_random_phase(16'd511, 16'd0, 25);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      byte_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (byte_valid && !byte_stall) begin
        if (pending_bytes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected byte %h last %b reply %h/%h",
                     frame_byte, last_byte, reply_address, reply_check);
        end else begin
          want = pending_bytes.pop_front();
          if (frame_byte !== want.data || last_byte !== want.last ||
              reply_address !== want.raddr || reply_check !== want.rchk) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("byte mismatch: expected %h/%b/%h/%h got %h/%b/%h/%h",
                       want.data, want.last, want.raddr, want.rchk,
                       frame_byte, last_byte, reply_address, reply_check);
          end
        end
        stall_left = pick_wait();
      end
      byte_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (byte_valid && !byte_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_config_extremes();
    test_random_traffic();
    wait_frames_out();
    if (mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/scfe_pkg.sv
src/scfe_pulse_pipe.sv
src/scfe_serializer.sv
src/stepper_command_frame_encoder.sv
src/scfe_checker.sv
bench/tb_stepper_command_frame_encoder.sv
